// ----- rtl/iso8583_message_parser_assert.svh -----
// Assertion macros used by the port-level checker.
`ifndef ISO8583_MESSAGE_PARSER_ASSERT_SVH
`define ISO8583_MESSAGE_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ISOMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ISOMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/isomp_pkg.sv -----
// Types, codes and helpers of the ISO 8583 message parser.
`default_nettype none
package isomp_pkg;

  localparam int unsigned TableDepth = 129;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrTooLong  = 3'd1;
  localparam logic [2:0] ErrUndefFmt = 3'd2;
  localparam logic [2:0] ErrEarlyEnd = 3'd3;
  localparam logic [2:0] ErrBadDef0  = 3'd4;
  localparam logic [2:0] ErrBadDigit = 3'd5;

  localparam logic [1:0] FmtBinary = 2'd2;
  localparam logic [1:0] FmtUndef  = 2'd3;

  typedef struct packed {
    logic [7:0] field_number;
    logic [7:0] out_byte;
    logic       field_end;
    logic       message_done;
    logic [2:0] error_code;
  } result_t;

  // Returns {valid, value} of one hexadecimal character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/iso8583_message_parser.sv -----
// ISO 8583 message parser top level: field splitter around a definition table memory.
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tuser action, tlast last_byte, tdata entry/data
//   m_axis    out  tvalid/tready         tuser done/error, tlast field_end, tdata field/byte
//   cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One word per cycle on s_axis while the output buffer has room; the next present
// field is found by a priority encoder over the bitmap, and its definition is read
// ahead from the table memory (one write and one read port).
// Results go through a two-entry output buffer; s_axis stalls only when both hold.
// Reset clears the parse state and the output buffer; the table needs no clearing pass.
`default_nettype none
module iso8583_message_parser #(
  parameter int unsigned FIELD_COUNT      = 128,
  parameter int unsigned MAX_FIELD_LENGTH = 999
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] entry_index, [9:8] entry_format, [11:10] entry_prefix_digits,
  // [21:12] entry_max_length, [29:22] data_byte, [31:30] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] action
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] field_number, [15:8] out_byte
  output logic [15:0]      m_axis_tdata,
  // [0] message_done, [3:1] error_code
  output logic [3:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [3:0]  cfg_data_i
);
  import isomp_pkg::*;

  localparam logic [2:0] PhType   = 3'd0;
  localparam logic [2:0] PhBitmap = 3'd1;
  localparam logic [2:0] PhSeek   = 3'd2;
  localparam logic [2:0] PhPrefix = 3'd3;
  localparam logic [2:0] PhBody   = 3'd4;
  localparam logic [2:0] PhWait   = 3'd5;

  localparam logic [9:0] MaxLen = 10'(MAX_FIELD_LENGTH);

  logic [13:0] mem_q [TableDepth];
  logic [13:0] rdata_q, fwd_data_q;
  logic        fwd_q;
  logic        mem_we;
  logic [7:0]  nf_d, nf_q;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  cur_q, cur_d;
  logic [9:0]  left_q, left_d;
  logic [1:0]  pdl_q, pdl_d;
  logic [9:0]  pv_q, pv_d;
  logic [5:0]  sec_q, sec_d;
  logic [3:0]  hexhi_q, hexhi_d;
  logic        ext_q, ext_d;
  logic [63:0] pres_q [2];
  logic [63:0] pres_d [2];
  logic [128:0] cons_q, cons_d;
  logic [1:0]  cfmt_q, cfmt_d;
  logic [9:0]  clen_q, clen_d;
  logic [1:0]  pd0_q, pd0_d;
  logic [3:0]  tilen_q;
  logic        hex_q;

  logic        s_acc;
  logic        have;
  result_t     res;
  result_t     e0_q, e1_q;
  logic        ov_q, sv_q;

  logic [13:0] mdef;
  logic [13:0] wdef;
  logic [7:0]  widx;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !sv_q;
  assign cfg_ready_o   = 1'b1;
  assign mdef          = fwd_q ? fwd_data_q : rdata_q;
  assign widx          = s_axis_tdata[7:0];
  assign wdef          = {s_axis_tdata[9:8], s_axis_tdata[11:10], s_axis_tdata[21:12]};

  // Next present field above the current one that takes bytes.
  always_comb begin
    logic [127:0] cand;
    logic [6:0]   fi;
    cand = '0;
    for (int f = 2; f <= 128; f++) begin
      fi = 7'(f - 1);
      cand[f-1] = (f <= (ext_d ? 128 : 64)) && (f <= int'(FIELD_COUNT)) &&
                  (f > int'(cur_d)) && pres_d[fi[6]][6'(63 - int'(fi[5:0]))] &&
                  cons_d[f];
    end
    nf_d = 8'd0;
    for (int f = 128; f >= 2; f--) begin
      if (cand[f-1]) begin
        nf_d = 8'(f);
      end
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [4:0]  hx;
    logic        ext_e;
    logic [5:0]  tot;
    logic [7:0]  mb;
    logic        do_prefix, do_body, finish;
    logic [2:0]  fail;
    logic [1:0]  pfmt, pdl_in;
    logic [9:0]  plen, pv_in, pvn, lim, lin, ln;
    logic [13:0] pvm;
    b = s_axis_tdata[29:22];
    hx = hex_value(b);
    ext_e = 1'b0; tot = '0; mb = '0;
    do_prefix = 1'b0; do_body = 1'b0; finish = 1'b0; fail = ErrNone;
    pfmt = cfmt_q; plen = clen_q; pdl_in = pdl_q; pv_in = pv_q; lin = left_q;
    pvn = '0; lim = '0; ln = '0; pvm = '0;
    phase_d = phase_q; cur_d = cur_q; left_d = left_q; pdl_d = pdl_q; pv_d = pv_q;
    sec_d = sec_q; hexhi_d = hexhi_q; ext_d = ext_q; pres_d = pres_q;
    cons_d = cons_q; cfmt_d = cfmt_q; clen_d = clen_q; pd0_d = pd0_q;
    mem_we = 1'b0;
    have = 1'b0;
    res = '0;
    if (s_acc && !s_axis_tuser && widx <= 8'd128) begin
      mem_we = 1'b1;
      cons_d[widx] = (wdef[13:12] == FmtUndef) || (wdef[11:10] != 2'd0) ||
                     (wdef[9:0] != 10'd0);
      if (widx == 8'd0) begin
        pd0_d = wdef[11:10];
      end
      if (widx == cur_q) begin
        cfmt_d = wdef[13:12];
        clen_d = wdef[9:0];
      end
    end
    if (s_acc && s_axis_tuser) begin
      unique case (phase_q)
        PhType: begin
          if (sec_q == 6'd0 && (pd0_q != 2'd0 || tilen_q == 4'd0)) begin
            fail = ErrBadDef0;
          end else begin
            have = 1'b1;
            res.field_number = 8'd0;
            res.out_byte = b;
            sec_d = sec_q + 6'd1;
            if (sec_d >= {2'b0, tilen_q}) begin
              res.field_end = 1'b1;
              phase_d = PhBitmap;
              sec_d = '0; cur_d = 8'd1; ext_d = 1'b0;
              pres_d[0] = '0; pres_d[1] = '0;
            end
          end
        end
        PhBitmap: begin
          if (!hex_q) begin
            ext_e = (sec_q == 6'd0) ? b[7] : ext_q;
            ext_d = ext_e;
            tot = ext_e ? 6'd16 : 6'd8;
            pres_d[sec_q[3]] = {pres_q[sec_q[3]][55:0], b};
            have = 1'b1;
            res.field_number = 8'd1;
            res.out_byte = b;
            sec_d = sec_q + 6'd1;
            finish = (sec_d >= tot);
          end else if (!hx[4]) begin
            fail = ErrBadDigit;
          end else begin
            ext_e = (sec_q == 6'd0) ? hx[3] : ext_q;
            ext_d = ext_e;
            tot = ext_e ? 6'd32 : 6'd16;
            sec_d = sec_q + 6'd1;
            if (!sec_q[0]) begin
              hexhi_d = hx[3:0];
            end else begin
              mb = {hexhi_q, hx[3:0]};
              pres_d[sec_q[4]] = {pres_q[sec_q[4]][55:0], mb};
              have = 1'b1;
              res.field_number = 8'd1;
              res.out_byte = mb;
              finish = (sec_d >= tot);
            end
          end
        end
        PhSeek: begin
          if (nf_q == 8'd0) begin
            phase_d = PhWait;
          end else begin
            cur_d = nf_q;
            cfmt_d = mdef[13:12];
            clen_d = mdef[9:0];
            if (mdef[11:10] == 2'd0) begin
              if (mdef[9:0] > MaxLen) begin
                fail = ErrTooLong;
              end else if (mdef[13:12] == FmtUndef) begin
                fail = ErrUndefFmt;
              end else begin
                lin = mdef[9:0];
                phase_d = PhBody;
                do_body = 1'b1;
              end
            end else begin
              pfmt = mdef[13:12];
              plen = mdef[9:0];
              pdl_in = mdef[11:10];
              pv_in = '0;
              phase_d = PhPrefix;
              do_prefix = 1'b1;
            end
          end
        end
        PhPrefix: do_prefix = 1'b1;
        PhBody:   do_body = 1'b1;
        default:  phase_d = PhWait;
      endcase
      if (do_body) begin
        have = 1'b1;
        res.field_number = cur_d;
        res.out_byte = b;
        ln = (lin != 10'd0) ? lin - 10'd1 : 10'd0;
        left_d = ln;
        finish = (ln == 10'd0);
      end
      if (do_prefix) begin
        if (b < 8'h30 || b > 8'h39) begin
          fail = ErrBadDigit;
        end else begin
          pvm = {1'b0, pv_in, 3'b0} + {3'b0, pv_in, 1'b0} + {10'd0, 4'(b - 8'h30)};
          pvn = pvm[9:0];
          pv_d = pvn;
          pdl_d = (pdl_in != 2'd0) ? pdl_in - 2'd1 : 2'd0;
          if (pfmt == FmtBinary) begin
            have = 1'b1;
            res.field_number = cur_d;
            res.out_byte = b;
          end
          if (pdl_d == 2'd0) begin
            lim = (plen > MaxLen) ? MaxLen : plen;
            if (pvn > lim) begin
              fail = ErrTooLong;
            end else if (pfmt == FmtUndef) begin
              fail = ErrUndefFmt;
            end else begin
              left_d = pvn;
              if (pvn == 10'd0) begin
                have = 1'b1;
                res.field_number = cur_d;
                res.out_byte = (pfmt == FmtBinary) ? b : 8'd0;
                finish = 1'b1;
              end else begin
                phase_d = PhBody;
              end
            end
          end
        end
      end
      if (finish) begin
        res.field_end = 1'b1;
        if (nf_d != 8'd0) begin
          phase_d = PhSeek;
        end else begin
          res.message_done = 1'b1;
          phase_d = PhWait;
        end
      end
      if (fail != ErrNone) begin
        have = 1'b1;
        res = '0;
        res.field_number = cur_d;
        res.error_code = fail;
        phase_d = PhWait;
      end
      if (s_axis_tlast) begin
        if (phase_d != PhWait) begin
          if (!have) begin
            res = '0;
            res.field_number = cur_d;
          end
          have = 1'b1;
          res.message_done = 1'b0;
          res.error_code = ErrEarlyEnd;
        end
        phase_d = PhType;
        cur_d = '0; left_d = '0; pdl_d = '0; pv_d = '0; sec_d = '0;
        hexhi_d = '0; ext_d = 1'b0; pres_d[0] = '0; pres_d[1] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[widx] <= wdef;
    end
    rdata_q    <= mem_q[nf_d];
    fwd_q      <= mem_we && (widx == nf_d);
    fwd_data_q <= wdef;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType;
      cur_q <= '0; left_q <= '0; pdl_q <= '0; pv_q <= '0; sec_q <= '0;
      hexhi_q <= '0; ext_q <= 1'b0; pres_q[0] <= '0; pres_q[1] <= '0;
      cons_q <= '0; cfmt_q <= '0; clen_q <= '0; pd0_q <= '0; nf_q <= '0;
      tilen_q <= 4'd4; hex_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cur_q <= cur_d; left_q <= left_d; pdl_q <= pdl_d; pv_q <= pv_d; sec_q <= sec_d;
      hexhi_q <= hexhi_d; ext_q <= ext_d; pres_q <= pres_d;
      cons_q <= cons_d; cfmt_q <= cfmt_d; clen_q <= clen_d; pd0_q <= pd0_d; nf_q <= nf_d;
      if (cfg_valid_i && cfg_index_i == 8'd0) begin
        tilen_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == 8'd1) begin
        hex_q <= cfg_data_i[0];
      end
    end
  end

  // Two-entry output buffer: e0 drives the port, e1 holds the skid word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      unique case ({s_acc && have, ov_q && m_axis_tready})
        2'b10: begin
          if (!ov_q) ov_q <= 1'b1;
          else sv_q <= 1'b1;
        end
        2'b01: begin
          if (sv_q) sv_q <= 1'b0;
          else ov_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case ({s_acc && have, ov_q && m_axis_tready})
      2'b10: begin
        if (!ov_q) e0_q <= res;
        else e1_q <= res;
      end
      2'b01: begin
        if (sv_q) e0_q <= e1_q;
      end
      2'b11: begin
        if (sv_q) begin
          e0_q <= e1_q;
          e1_q <= res;
        end else begin
          e0_q <= res;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {e0_q.out_byte, e0_q.field_number};
  assign m_axis_tuser  = {e0_q.error_code, e0_q.message_done};
  assign m_axis_tlast  = e0_q.field_end;

endmodule
`default_nettype wire

// ----- rtl/isomp_checker.sv -----
// Port-level checker for the ISO 8583 message parser and its bind.
`default_nettype none
`include "iso8583_message_parser_assert.svh"
module isomp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import isomp_pkg::*;

  logic [2:0] err;
  assign err = m_axis_tuser[3:1];

  `ISOMP_ASSERT_NOW(a_err_range, m_axis_tvalid, err == ErrNone || err == ErrTooLong || err == ErrUndefFmt || err == ErrEarlyEnd || err == ErrBadDef0 || err == ErrBadDigit, "error code out of range")
  `ISOMP_ASSERT_NOW(a_err_clean, m_axis_tvalid && err != ErrNone && err != ErrEarlyEnd, m_axis_tdata[15:8] == 8'd0 && !m_axis_tlast && !m_axis_tuser[0], "error word carries content")
  `ISOMP_ASSERT_NOW(a_done_ends, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && err == ErrNone, "message done without clean field end")
  `ISOMP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output word changed")

endmodule

bind iso8583_message_parser isomp_checker u_isomp_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
